FILE: rtl/core/mh64_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mh64_pkg;

    // mixing multiplier and shift of the murmur 64a hash
    localparam logic [63:0] MIX_M = 64'hc6a4a7935bd1e995;
    localparam int unsigned MIX_R = 47;

    // default depth of the queue between front and back
    localparam int unsigned QUEUE_DEPTH = 2;

    // one classified word on its way from front to back
    typedef struct packed {
        logic [63:0] word;   // bytes beyond the count already cleared
        logic [30:0] len;    // string length, used on the first word only
        logic        first;  // first word of a string: hash is seeded
        logic        full;   // eight bytes: full word mix
        logic        tail;   // one to seven bytes: tail mix
        logic        fin;    // string ends with this word
    } mh64_item_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_LEN,
        BK_BODY,
        BK_K1,
        BK_K2,
        BK_H,
        BK_FIN,
        BK_OUT
    } mh64_bk_state_t;

    // xorshift by the mixing shift
    function automatic logic [63:0] xorshift(input logic [63:0] v);
        xorshift = v ^ (v >> MIX_R);
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/mh64_mul.sv
`timescale 1ns / 1ps
`default_nettype none

module mh64_mul (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [63:0] a,
    output logic             done,
    output logic [63:0]      product
);
    import mh64_pkg::*;

    localparam logic [31:0] M_LO = MIX_M[31:0];
    localparam logic [31:0] M_HI = MIX_M[63:32];

    logic [63:0] a_reg;
    logic [63:0] acc_reg;
    logic [1:0]  step_reg;
    logic        busy_reg;
    logic        done_reg;

    logic [31:0] op_x;
    logic [31:0] op_y;
    logic [63:0] part;

    // low 64 bits of a * m from three 32 x 32 partial products
    always_comb
    begin
        unique case (step_reg)
            2'd0:
            begin
                op_x = a_reg[31:0];
                op_y = M_LO;
            end
            2'd1:
            begin
                op_x = a_reg[31:0];
                op_y = M_HI;
            end
            default:
            begin
                op_x = a_reg[63:32];
                op_y = M_LO;
            end
        endcase
        part = {32'd0, op_x} * {32'd0, op_y};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= 2'd0;
        end
        else
        begin
            done_reg <= busy_reg && (step_reg == 2'd2);
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= 2'd0;
            end
            else if (busy_reg)
            begin
                if (step_reg == 2'd2)
                begin
                    busy_reg <= 1'b0;
                    step_reg <= 2'd0;
                end
                else
                begin
                    step_reg <= step_reg + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg <= a;
        end
        if (busy_reg)
        begin
            if (step_reg == 2'd0)
            begin
                acc_reg <= part;
            end
            else
            begin
                acc_reg[63:32] <= acc_reg[63:32] + part[31:0];
            end
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

`default_nettype wire

FILE: rtl/core/mh64_front.sv
`timescale 1ns / 1ps
`default_nettype none

module mh64_front #(
    parameter int unsigned DEPTH = mh64_pkg::QUEUE_DEPTH
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    output logic                     full,
    input  wire logic [63:0]         data_word,
    input  wire logic [3:0]          byte_count,
    input  wire logic [30:0]         string_len,
    input  wire logic                last,
    output logic                     q_valid,
    output mh64_pkg::mh64_item_t     q_item,
    input  wire logic                q_pop
);
    import mh64_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    mh64_item_t       mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             inside_reg;

    logic       accept;
    logic       take;
    logic [3:0] cnt_clamped;
    logic       is_full;
    logic [63:0] masked;
    mh64_item_t  item;

    assign full    = (cnt_reg == CNT_FULL);
    assign accept  = push && !full;
    assign q_valid = (cnt_reg != '0);
    assign take    = q_pop && q_valid;
    assign q_item  = mem_reg[rd_ptr_reg];

    // classify: clamp the count, clear unused bytes, mark start and end
    always_comb
    begin
        cnt_clamped = byte_count[3] ? 4'd8 : byte_count;
        is_full     = byte_count[3];
        for (int i = 0; i < 8; i++)
        begin
            masked[i*8 +: 8] = (4'(i) < cnt_clamped) ? data_word[i*8 +: 8] : 8'd0;
        end
        item.word  = masked;
        item.len   = string_len;
        item.first = !inside_reg;
        item.full  = is_full;
        item.tail  = !is_full && (cnt_clamped != 4'd0);
        item.fin   = last || !is_full;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
            inside_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
                inside_reg <= !item.fin;
            end
            if (take)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (accept && !take)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (take && !accept)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mem_reg[wr_ptr_reg] <= item;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/mh64_back.sv
`timescale 1ns / 1ps
`default_nettype none

module mh64_back (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic [63:0]          seed,
    input  wire logic                 q_valid,
    input  wire mh64_pkg::mh64_item_t q_item,
    output logic                      q_pop,
    output logic                      res_valid,
    output logic [63:0]               res_value,
    input  wire logic                 pop
);
    import mh64_pkg::*;

    mh64_bk_state_t state_reg, state_next;
    mh64_item_t     item_reg, item_next;
    logic [63:0]    h_reg, h_next;
    logic           out_valid_reg, out_valid_next;
    logic [63:0]    out_hash_reg, out_hash_next;

    logic        mul_start;
    logic [63:0] mul_a;
    logic        mul_done;
    logic [63:0] mul_p;

    mh64_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (mul_a),
        .done    (mul_done),
        .product (mul_p)
    );

    always_comb
    begin
        state_next     = state_reg;
        item_next      = item_reg;
        h_next         = h_reg;
        out_valid_next = out_valid_reg && !pop;
        out_hash_next  = out_hash_reg;
        mul_start      = 1'b0;
        mul_a          = '0;
        q_pop          = 1'b0;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop     = 1'b1;
                    item_next = q_item;
                    if (q_item.first)
                    begin
                        mul_start  = 1'b1;
                        mul_a      = {33'd0, q_item.len};
                        state_next = BK_LEN;
                    end
                    else
                    begin
                        state_next = BK_BODY;
                    end
                end
            end
            BK_LEN:
            begin
                if (mul_done)
                begin
                    h_next     = seed ^ mul_p;
                    state_next = BK_BODY;
                end
            end
            BK_BODY:
            begin
                mul_start = 1'b1;
                priority if (item_reg.full)
                begin
                    mul_a      = item_reg.word;
                    state_next = BK_K1;
                end
                else if (item_reg.tail)
                begin
                    mul_a      = h_reg ^ item_reg.word;
                    state_next = BK_H;
                end
                else
                begin
                    mul_a      = xorshift(h_reg);
                    state_next = BK_FIN;
                end
            end
            BK_K1:
            begin
                if (mul_done)
                begin
                    mul_start  = 1'b1;
                    mul_a      = xorshift(mul_p);
                    state_next = BK_K2;
                end
            end
            BK_K2:
            begin
                if (mul_done)
                begin
                    mul_start  = 1'b1;
                    mul_a      = h_reg ^ mul_p;
                    state_next = BK_H;
                end
            end
            BK_H:
            begin
                if (mul_done)
                begin
                    h_next = mul_p;
                    if (item_reg.fin)
                    begin
                        mul_start  = 1'b1;
                        mul_a      = xorshift(mul_p);
                        state_next = BK_FIN;
                    end
                    else
                    begin
                        state_next = BK_IDLE;
                    end
                end
            end
            BK_FIN:
            begin
                if (mul_done)
                begin
                    h_next     = xorshift(mul_p);
                    state_next = BK_OUT;
                end
            end
            BK_OUT:
            begin
                // wait for the result register to free up
                if (!out_valid_reg || pop)
                begin
                    out_valid_next = 1'b1;
                    out_hash_next  = h_reg;
                    state_next     = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        h_reg        <= h_next;
        out_hash_reg <= out_hash_next;
    end

    assign res_valid = out_valid_reg;
    assign res_value = out_hash_reg;

endmodule

`default_nettype wire

FILE: rtl/core/murmur64a_string_hash.sv
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  handshake            word
// input     in         push / full          data_word, byte_count, string_len, last
// result    out        empty / pop          hash_value
// config    in         hash_seed_wr_en      hash_seed
//
// one shared 32 x 32 multiplier does each multiply by m as three partial
// products plus a hand-over; a full word needs 3 multiplies;
// a string's first word adds a seeding multiply, its end adds the finalising
// multiply and the result load; a tail word needs one multiply and an empty word none, plus the end
// reset clears the queue, the string tracking, the sequencer and the seed
// input stalls only on a full queue; a waiting result holds back the sequencer

module murmur64a_string_hash #(
    parameter int unsigned QUEUE_DEPTH = mh64_pkg::QUEUE_DEPTH
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // input words
    input  wire logic        push,
    output logic             full,
    input  wire logic [63:0] data_word,
    input  wire logic [3:0]  byte_count,
    input  wire logic [30:0] string_len,
    input  wire logic        last,
    // results
    output logic             empty,
    input  wire logic        pop,
    output logic [63:0]      hash_value,
    // seed register
    input  wire logic        hash_seed_wr_en,
    input  wire logic [63:0] hash_seed
);
    import mh64_pkg::*;

    logic [63:0] seed_reg;
    logic        q_valid;
    mh64_item_t  q_item;
    logic        q_pop;
    logic        res_valid;

    // the user must write the seed only while the block is idle; the block itself does not enforce it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= '0;
        end
        else if (hash_seed_wr_en)
        begin
            seed_reg <= hash_seed;
        end
    end

    // front: takes words, clamps counts, clears stray bytes, marks first and end
    mh64_front #(
        .DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .data_word  (data_word),
        .byte_count (byte_count),
        .string_len (string_len),
        .last       (last),
        .q_valid    (q_valid),
        .q_item     (q_item),
        .q_pop      (q_pop)
    );

    // back: seeds, mixes, finalises and holds the result word
    mh64_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .seed      (seed_reg),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .res_valid (res_valid),
        .res_value (hash_value),
        .pop       (pop)
    );

    assign empty = !res_valid;

endmodule

`default_nettype wire

FILE: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    // hash constants, kept local so the checker stands apart from the design
    localparam logic [63:0] HASH_M = 64'hc6a4a7935bd1e995;
    localparam int unsigned HASH_R = 47;

    // cycles to let the sequencer settle once nothing is outstanding
    localparam int SETTLE_CYCLES  = 64;
    // length of the long receiver hold-off
    localparam int RX_HOLD_CYCLES = 400;

    // one input word as it goes through the handshake
    typedef struct packed {
        logic [63:0] data;
        logic [3:0]  count;
        logic [30:0] len;
        logic        fin;
    } str_word_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [63:0] data_word = '0;
    logic [3:0]  byte_count = '0;
    logic [30:0] string_len = '0;
    logic        last = 1'b0;
    logic        empty;
    logic        pop = 1'b0;
    logic [63:0] hash_value;
    logic        hash_seed_wr_en = 1'b0;
    logic [63:0] hash_seed = '0;

    murmur64a_string_hash u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .push            (push),
        .full            (full),
        .data_word       (data_word),
        .byte_count      (byte_count),
        .string_len      (string_len),
        .last            (last),
        .empty           (empty),
        .pop             (pop),
        .hash_value      (hash_value),
        .hash_seed_wr_en (hash_seed_wr_en),
        .hash_seed       (hash_seed)
    );

    // words waiting to be offered, and hashes owed by the block
    str_word_t   words_to_send[$];
    logic [63:0] hashes_due[$];

    // predictor state: seed copy, running hash, inside-a-string flag
    logic [63:0] seed_copy = '0;
    logic [63:0] run_hash = '0;
    logic        in_string = 1'b0;

    // traffic shaping, set from the sequence block at the falling edge
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    logic        send_hold = 1'b0;
    logic        rx_hold = 1'b0;
    event        rx_hold_kick;

    // stimulus bookkeeping: word count and whether the last string is still open
    int          words_queued = 0;
    logic        gen_open = 1'b0;
    int          err_count = 0;

    str_word_t   cur_word;
    logic [63:0] predicted;

    initial
    begin
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // predictor: one accepted word in, at most one finished hash out
    // ------------------------------------------------------------------
    function automatic bit hash_word(input str_word_t w, output logic [63:0] hv);
        logic [63:0] h;
        logic [63:0] k;
        logic [63:0] mask;
        logic [3:0]  n;
        logic        ends;
        // counts above eight behave as a full word
        n = (w.count > 4'd8) ? 4'd8 : w.count;
        ends = w.fin;
        hv = '0;
        // first word of a string seeds the hash with the given length
        if (!in_string)
        begin
            run_hash = seed_copy ^ (64'(w.len) * HASH_M);
            in_string = 1'b1;
        end
        h = run_hash;
        if (n == 4'd8)
        begin
            k = w.data * HASH_M;
            k = k ^ (k >> HASH_R);
            k = k * HASH_M;
            h = (h ^ k) * HASH_M;
        end
        else
        begin
            // tail: only the counted bytes enter, and a short word always ends the string
            if (n != 4'd0)
            begin
                mask = (64'd1 << (8 * n)) - 64'd1;
                h = (h ^ (w.data & mask)) * HASH_M;
            end
            ends = 1'b1;
        end
        if (!ends)
        begin
            run_hash = h;
            return 1'b0;
        end
        // finalise
        h = h ^ (h >> HASH_R);
        h = h * HASH_M;
        h = h ^ (h >> HASH_R);
        run_hash = '0;
        in_string = 1'b0;
        hv = h;
        return 1'b1;
    endfunction

    task automatic flag_error(input string msg);
        err_count++;
        $display("%0t ERROR %s", $time, msg);
    endtask

    // ------------------------------------------------------------------
    // driver: offers queued words, predicts each one as it is taken
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            push       <= 1'b0;
            data_word  <= '0;
            byte_count <= '0;
            string_len <= '0;
            last       <= 1'b0;
        end
        else
        begin
            if (push && !full)
            begin
                if (hash_word(cur_word, predicted))
                    hashes_due.push_back(predicted);
            end
            // a word still on offer stays put until the block takes it
            if (!push || !full)
            begin
                if (words_to_send.size() != 0 && !send_hold &&
                    $urandom_range(99) >= send_idle_pct)
                begin
                    cur_word = words_to_send.pop_front();
                    push       <= 1'b1;
                    data_word  <= cur_word.data;
                    byte_count <= cur_word.count;
                    string_len <= cur_word.len;
                    last       <= cur_word.fin;
                end
                else
                begin
                    push <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor: takes hashes at random and checks them in order
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pop <= 1'b0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (hashes_due.size() == 0)
                    flag_error($sformatf("hash %h with none owed", hash_value));
                else if (hash_value !== hashes_due[0])
                begin
                    flag_error($sformatf("hash_value got %h want %h",
                                         hash_value, hashes_due[0]));
                    void'(hashes_due.pop_front());
                end
                else
                    void'(hashes_due.pop_front());
            end
            pop <= !rx_hold && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // long receiver hold-off, counted here so the sender keeps pushing meanwhile
    initial
    begin
        forever
        begin
            @(rx_hold_kick);
            rx_hold = 1'b1;
            repeat (RX_HOLD_CYCLES) @(negedge clk);
            rx_hold = 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    task automatic queue_word(input logic [63:0] d, input logic [3:0] c,
                              input logic [30:0] l, input logic f);
        str_word_t w;
        w.data  = d;
        w.count = c;
        w.len   = l;
        w.fin   = f;
        words_to_send.push_back(w);
        words_queued++;
        // only a full word without last leaves the string open
        gen_open = (c >= 4'd8) && !f;
    endtask

    // well-formed string, mostly short, now and then a long one or a wrong length
    task automatic add_random_string();
        int          n;
        int          nfull;
        int          tail;
        int          i;
        logic [30:0] len_field;
        logic        closed;
        if ($urandom_range(99) < 8)
            n = $urandom_range(200, 64);
        else
            n = $urandom_range(40);
        len_field = ($urandom_range(9) == 0) ? 31'($urandom) : 31'(n);
        nfull = n / 8;
        tail = n % 8;
        closed = 1'b0;
        for (i = 0; i < nfull; i++)
        begin
            // last on the final full word, or else a separate empty last word
            closed = (tail == 0) && (i == nfull - 1) && ($urandom_range(3) != 0);
            queue_word({$urandom, $urandom},
                       ($urandom_range(7) == 0) ? 4'($urandom_range(15, 9)) : 4'd8,
                       (i == 0) ? len_field : 31'($urandom), closed);
        end
        if (!closed)
            queue_word({$urandom, $urandom}, 4'(tail),
                       (nfull == 0) ? len_field : 31'($urandom),
                       (tail == 0) ? 1'b1 : 1'($urandom_range(1)));
    endtask

    // mostly whole strings, with the odd stray word thrown in
    task automatic fill_random(input int n_words);
        int target;
        target = words_queued + n_words;
        while (words_queued < target)
        begin
            if ($urandom_range(9) == 0)
                queue_word({$urandom, $urandom}, 4'($urandom_range(15)),
                           31'($urandom), 1'($urandom_range(1)));
            else
                add_random_string();
        end
    endtask

    // leave no string half done at the end of a phase
    task automatic close_string();
        if (gen_open)
            queue_word({$urandom, $urandom}, 4'd0, 31'($urandom), 1'b1);
    endtask

    // seed is only written while the block has nothing in hand
    task automatic load_seed(input logic [63:0] v);
        @(posedge clk);
        hash_seed_wr_en <= 1'b1;
        hash_seed       <= v;
        @(posedge clk);
        hash_seed_wr_en <= 1'b0;
        seed_copy = v;
        @(negedge clk);
    endtask

    // everything sent and every hash back, then let the sequencer go quiet
    task automatic wait_drained();
        while (words_to_send.size() != 0 || push || hashes_due.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic run_phase(input logic [63:0] seed, input int tx_idle,
                             input int rx_stall, input int n_words);
        load_seed(seed);
        send_idle_pct = tx_idle;
        recv_stall_pct = rx_stall;
        fill_random(n_words);
        close_string();
        wait_drained();
    endtask

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------
    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed part, zero seed, no idling
        load_seed(64'd0);
        // empty string
        queue_word(64'd0, 4'd0, 31'd0, 1'b1);
        // single full word carrying last, all bits high
        queue_word('1, 4'd8, 31'd8, 1'b1);
        // seven-byte tail only, top byte set beyond the count
        queue_word('1, 4'd7, 31'd7, 1'b1);
        // one-byte tail without last still closes the string
        queue_word(64'hffff_ffff_ffff_ffa5, 4'd1, 31'd1, 1'b0);
        // count above eight at the largest length, then a full word with last
        queue_word(64'h0123_4567_89ab_cdef, 4'd15, 31'h7fff_ffff, 1'b0);
        queue_word(64'hfedc_ba98_7654_3210, 4'd12, 31'($urandom), 1'b1);
        // two full words, then an empty last word for no tail
        queue_word({$urandom, $urandom}, 4'd8, 31'd16, 1'b0);
        queue_word({$urandom, $urandom}, 4'd8, 31'($urandom), 1'b0);
        queue_word({$urandom, $urandom}, 4'd0, 31'($urandom), 1'b1);
        // length disagreeing with the data: eleven bytes sent, five claimed
        queue_word(64'd0, 4'd8, 31'd5, 1'b0);
        queue_word({$urandom, $urandom}, 4'd3, 31'($urandom), 1'b1);
        // oversize count with last, zero length
        queue_word({$urandom, $urandom}, 4'd9, 31'd0, 1'b1);
        // run of oversize counts
        queue_word({$urandom, $urandom}, 4'd10, 31'd32, 1'b0);
        queue_word({$urandom, $urandom}, 4'd11, 31'($urandom), 1'b0);
        queue_word({$urandom, $urandom}, 4'd13, 31'($urandom), 1'b0);
        queue_word({$urandom, $urandom}, 4'd14, 31'($urandom), 1'b1);
        // remaining tail sizes
        queue_word({$urandom, $urandom}, 4'd2, 31'd2, 1'b1);
        queue_word({$urandom, $urandom}, 4'd4, 31'd4, 1'b1);
        queue_word({$urandom, $urandom}, 4'd5, 31'd5, 1'b0);
        queue_word({$urandom, $urandom}, 4'd6, 31'd6, 1'b1);
        wait_drained();

        // random part over several seeds and idling patterns
        run_phase('1, 0, 0, 90);
        run_phase({$urandom, $urandom}, 69, 0, 90);
        run_phase({$urandom, $urandom}, 0, 69, 90);
        run_phase(64'h8000_0000_0000_0001, 15, 15, 90);

        // pressure: receiver holds off long enough for the input to back up
        load_seed({$urandom, $urandom});
        send_idle_pct = 0;
        recv_stall_pct = 0;
        fill_random(60);
        -> rx_hold_kick;
        wait (rx_hold == 1'b1);
        wait (rx_hold == 1'b0);
        @(negedge clk);
        fill_random(30);
        close_string();
        // sender pauses mid-stream until every owed hash is back
        while (words_to_send.size() > 15)
            @(negedge clk);
        send_hold = 1'b1;
        while (push || hashes_due.size() != 0)
            @(negedge clk);
        send_hold = 1'b0;
        wait_drained();

        if (err_count == 0)
            $display("murmur64a_string_hash verification clean");
        else
            $display("murmur64a_string_hash verification failed");
        $finish;
    end

    // watchdog, far beyond the slowest correct run
    initial
    begin
        #2_000_000;
        $display("murmur64a_string_hash verification failed");
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/mh64_pkg.sv
rtl/core/mh64_mul.sv
rtl/core/mh64_front.sv
rtl/core/mh64_back.sv
rtl/core/murmur64a_string_hash.sv
verif/tb_top.sv
